[src/kev_pkg.sv]
// Shared types, constants and event mapping for the key event qualifier.
package kev_pkg;

    localparam int KEV_TIME_WIDTH_DEF = 32;
    localparam int KEV_NUM_KEYS       = 7;
    localparam int KEV_NUM_SHORT_ONLY = 5;   // up, down, left, right, ok
    localparam int KEV_KEY_A          = 5;
    localparam int KEV_KEY_B          = 6;
    localparam int KEV_ADDR_WIDTH     = 4;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_ROTATION   = 2'd2;
    localparam logic [1:0] REG_PRESENT    = 2'd3;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd800;
    localparam logic [1:0]  ROTATION_RST   = 2'd0;
    localparam logic [6:0]  PRESENT_RST    = 7'h7f;

    typedef enum logic [3:0] {
        EV_NONE   = 4'd0,
        EV_UP     = 4'd1,
        EV_DOWN   = 4'd2,
        EV_LEFT   = 4'd3,
        EV_RIGHT  = 4'd4,
        EV_OK     = 4'd5,
        EV_A      = 4'd6,
        EV_A_LONG = 4'd7,
        EV_B      = 4'd8,
        EV_B_LONG = 4'd9
    } kev_event_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [1:0]  rotation;
        logic [6:0]  present_mask;
    } kev_cfg_t;

    // direction remap, [rotation][up/down/left/right]
    localparam kev_event_t ROT_MAP [4][4] = '{
        '{EV_UP,    EV_DOWN,  EV_LEFT,  EV_RIGHT},
        '{EV_RIGHT, EV_LEFT,  EV_UP,    EV_DOWN },
        '{EV_DOWN,  EV_UP,    EV_RIGHT, EV_LEFT },
        '{EV_LEFT,  EV_RIGHT, EV_DOWN,  EV_UP   }
    };

    // event for a short press of one of the first five keys
    function automatic kev_event_t kev_short_event(input logic [1:0] rot,
                                                   input logic [2:0] key);
        kev_event_t ev;
        unique case (key)
            3'd0, 3'd1, 3'd2, 3'd3: ev = ROT_MAP[rot][key[1:0]];
            3'd4:                   ev = EV_OK;
            default:                ev = EV_NONE;
        endcase
        return ev;
    endfunction

endpackage

[src/kev_regs.sv]
// APB configuration registers of the key event qualifier.
module kev_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kev_pkg::KEV_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output kev_pkg::kev_cfg_t                 cfg
);
    import kev_pkg::*;

    kev_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms   <= DEBOUNCE_RST;
            cfg_reg.long_press_ms <= LONG_PRESS_RST;
            cfg_reg.rotation      <= ROTATION_RST;
            cfg_reg.present_mask  <= PRESENT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DEBOUNCE:   cfg_reg.debounce_ms   <= pwdata[15:0];
                REG_LONG_PRESS: cfg_reg.long_press_ms <= pwdata[15:0];
                REG_ROTATION:   cfg_reg.rotation      <= pwdata[1:0];
                REG_PRESENT:    cfg_reg.present_mask  <= pwdata[6:0];
                default:        cfg_reg.rotation      <= cfg_reg.rotation;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DEBOUNCE:   prdata = {16'd0, cfg_reg.debounce_ms};
            REG_LONG_PRESS: prdata = {16'd0, cfg_reg.long_press_ms};
            REG_ROTATION:   prdata = {30'd0, cfg_reg.rotation};
            REG_PRESENT:    prdata = {25'd0, cfg_reg.present_mask};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[src/key_event_qualifier.sv]
// Top level of the key event qualifier: beat pipeline, key state and priority check.
//
// Turns one sample of seven key levels (up, down, left, right, ok, A, B) plus
// the current millisecond time into exactly one key_event beat. Keys are checked
// in that priority order and only the first key that fires is reported; keys
// after it are not examined, so their state is left untouched. A short press
// fires while a key is down and more than debounce_ms have passed since that key
// last fired, so a held key auto-repeats. A and B first check for a long press,
// which fires once per hold after long_press_ms; a hold start of zero means "not
// held", so a press first seen at time zero starts its hold on the next sample.
// Direction events are remapped by the rotation register; keys cleared in
// present_mask never fire. All times are modulo 2^TIME_WIDTH. Throughput is one
// sample per clock while the result stage is not stalled: the whole seven-key
// check with its state update sits between the input register and the result
// register. in_stall follows out_stall only when both stages are full. Registers
// are written over APB (0x0 debounce_ms, 0x4 long_press_ms, 0x8 rotation,
// 0xC present_mask) and should only be changed while no beats are in flight.
module key_event_qualifier #(
    parameter int TIME_WIDTH = kev_pkg::KEV_TIME_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [31:0]                       now_ms,
    input  logic [6:0]                        key_levels,
    // event channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [3:0]                        key_event,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kev_pkg::KEV_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import kev_pkg::*;

    localparam int TW = TIME_WIDTH;

    kev_cfg_t cfg;

    // input stage
    logic          in_valid_reg;
    logic [TW-1:0] now_reg;
    logic [6:0]    lev_reg;
    logic          accept;
    logic          advance;

    // result stage
    logic          out_valid_reg;
    kev_event_t    event_reg;

    // key state
    logic [TW-1:0] last_fire_reg  [KEV_NUM_KEYS];
    logic [TW-1:0] last_fire_next [KEV_NUM_KEYS];
    logic [TW-1:0] hold_reg       [2];
    logic [TW-1:0] hold_next      [2];
    logic [1:0]    long_rep_reg;
    logic [1:0]    long_rep_next;
    kev_event_t    event_next;

    assign pready = 1'b1;

    kev_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // ---------------- handshake ----------------
    // the input stage moves on whenever the result slot is empty or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= TW'(now_ms);
            lev_reg <= key_levels;
        end
    end

    // ---------------- priority check ----------------
    always_comb
    begin
        logic          done;
        logic [TW-1:0] deb;
        logic [TW-1:0] lp;
        logic [TW-1:0] hs;
        logic          slot;
        logic [2:0]    key;

        deb           = TW'(cfg.debounce_ms);
        lp            = TW'(cfg.long_press_ms);
        done          = 1'b0;
        hs            = '0;
        event_next    = EV_NONE;
        last_fire_next = last_fire_reg;
        hold_next      = hold_reg;
        long_rep_next  = long_rep_reg;

        // up, down, left, right, ok: short press only
        for (int k = 0; k < KEV_NUM_SHORT_ONLY; k++)
        begin
            if (!done && cfg.present_mask[k] && lev_reg[k]
                && ((now_reg - last_fire_reg[k]) > deb))
            begin
                last_fire_next[k] = now_reg;
                event_next        = kev_short_event(cfg.rotation, 3'(k));
                done              = 1'b1;
            end
        end

        // A then B: long press check, then short press
        for (int s = 0; s < 2; s++)
        begin
            slot = 1'(s);
            key  = (s == 0) ? 3'(KEV_KEY_A) : 3'(KEV_KEY_B);
            if (!done && cfg.present_mask[key])
            begin
                if (lev_reg[key])
                begin
                    hs = (hold_reg[slot] == '0) ? now_reg : hold_reg[slot];
                    hold_next[slot] = hs;
                    if (!long_rep_reg[slot] && ((now_reg - hs) > lp))
                    begin
                        long_rep_next[slot] = 1'b1;
                        event_next = (s == 0) ? EV_A_LONG : EV_B_LONG;
                        done       = 1'b1;
                    end
                end
                else
                begin
                    hold_next[slot]     = '0;
                    long_rep_next[slot] = 1'b0;
                end
            end
            if (!done && cfg.present_mask[key] && lev_reg[key]
                && ((now_reg - last_fire_reg[key]) > deb))
            begin
                last_fire_next[key] = now_reg;
                event_next = (s == 0) ? EV_A : EV_B;
                done       = 1'b1;
            end
        end
    end

    // key state commits only when the sample is actually consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_fire_reg <= '{default: '0};
            hold_reg      <= '{default: '0};
            long_rep_reg  <= '0;
        end
        else if (advance)
        begin
            last_fire_reg <= last_fire_next;
            hold_reg      <= hold_next;
            long_rep_reg  <= long_rep_next;
        end
    end

    // ---------------- result stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg <= event_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_event = event_reg;

    // ---------------- assertions ----------------
    // a reported long press always belongs to a live hold
    assert property (@(posedge clk) disable iff (!rst_n)
        long_rep_reg[0] |-> (hold_reg[0] != '0))
        else $error("A long press flagged without a hold start");

    assert property (@(posedge clk) disable iff (!rst_n)
        long_rep_reg[1] |-> (hold_reg[1] != '0))
        else $error("B long press flagged without a hold start");

    // firing a long press must latch its once-per-hold flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (event_next == EV_A_LONG)) |=> long_rep_reg[0])
        else $error("A long press fired without latching its flag");

    // a new result only appears after a sample was consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result beat without a consumed sample");

endmodule
